/* design/cams_pkg.sv */
// ----------------------------------------------------------------------------
// cams_pkg
// Shared types, constants and helpers for the abbreviation match scorer.
// ----------------------------------------------------------------------------
package cams_pkg;

  localparam int MAX_TEXT_LEN = 64;
  localparam int MAX_ABBR_LEN = 16;

  localparam int POS_W   = 7;   // holds 0..MAX_TEXT_LEN
  localparam int LEN_W   = 5;   // holds 0..MAX_ABBR_LEN and the raw register
  localparam int IDX_W   = 4;   // indexes one abbreviation byte
  localparam int HITS_W  = 6;
  localparam int PAIRS_W = 5;
  localparam int SCORE_W = 12;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ABBR_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABBR_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABBR_LEN = 2'd2;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  localparam logic [SCORE_W-1:0] SCORE_EXACT     = 12'd1000;
  localparam logic [SCORE_W-1:0] SCORE_PREFIX    = 12'd900;   // 800 + 100
  localparam logic [SCORE_W-1:0] SCORE_SUBSTRING = 12'd500;   // 400 + 100
  localparam logic [SCORE_W-1:0] SCORE_SUBSEQ    = 12'd500;
  localparam logic [SCORE_W-1:0] SCORE_EMPTY     = 12'd100;
  localparam logic [SCORE_W-1:0] SCORE_PER_HIT   = 12'd50;
  localparam logic [SCORE_W-1:0] SCORE_PER_PAIR  = 12'd10;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_SUBSEQ    = 3'd1,
    KIND_SUBSTRING = 3'd2,
    KIND_PREFIX    = 3'd3,
    KIND_EXACT     = 3'd4,
    KIND_EMPTY     = 3'd5
  } kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    kind_t              kind;
    logic               too_long;
  } result_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return is_upper(c) ? (c + 8'd32) : c;
  endfunction

endpackage

/* design/context_abbrev_match_score.sv */
// ----------------------------------------------------------------------------
// context_abbrev_match_score
// Streams a candidate text byte by byte and scores it against a configured
// abbreviation: empty, exact, prefix, substring or greedy subsequence match.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid/in_ready, in_text_byte,        | input
//           | in_last_byte                            |
//  out      | out_valid/out_ready, out_score,         | output
//           | out_match_kind, out_text_too_long       |
//  cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data| input
//
//  One text byte is taken per cycle while in_ready is high; the running flags
//  and counters update in the cycle it transfers, and the score is registered
//  into the output register, or the skid entry while that is held. The two
//  entries keep input flowing while a result waits; in_ready drops only while
//  the skid entry is occupied. Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module context_abbrev_match_score
  import cams_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_last_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SCORE_W-1:0]   out_score,
  output logic [2:0]           out_match_kind,
  output logic                 out_text_too_long,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [CFG_W-1:0] abbr_lo_r;
  logic [CFG_W-1:0] abbr_hi_r;
  logic [LEN_W-1:0] abbr_len_r;

  // per-text state
  logic [POS_W-1:0]        pos_r,      pos_nxt;
  logic [LEN_W-1:0]        ptr_r,      ptr_nxt;
  logic                    pfx_ok_r,   pfx_ok_nxt;
  logic [MAX_ABBR_LEN-1:0] prog_r,     prog_nxt;
  logic                    found_r,    found_nxt;
  logic [7:0]              prev_r,     prev_nxt;
  logic                    prev_m_r,   prev_m_nxt;
  logic [HITS_W-1:0]       hits_r,     hits_nxt;
  logic [PAIRS_W-1:0]      pairs_r,    pairs_nxt;
  logic                    ovf_r,      ovf_nxt;

  // output register and skid entry
  logic    out_valid_r;
  result_t out_res_r;
  logic    skid_valid_r;
  result_t skid_res_r;

  logic            in_fire;
  logic            res_valid;
  result_t         res;
  logic [LEN_W-1:0] len;
  logic [MAX_ABBR_LEN-1:0][7:0] abbr_f;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign res_valid = in_fire & in_last_byte;

  assign len = (abbr_len_r > LEN_W'(MAX_ABBR_LEN)) ? LEN_W'(MAX_ABBR_LEN) : abbr_len_r;

  always @(*) begin
    for (int k = 0; k < 8; k++) begin
      abbr_f[k]   = fold_case(abbr_lo_r[k*8 +: 8]);
      abbr_f[k+8] = fold_case(abbr_hi_r[k*8 +: 8]);
    end
  end

  // state update for one byte
  always @(*) begin
    logic [7:0]              c;
    logic [MAX_ABBR_LEN-1:0] eq;
    logic                    matched;
    logic [IDX_W-1:0]        len_m1;

    pos_nxt    = pos_r;
    ptr_nxt    = ptr_r;
    pfx_ok_nxt = pfx_ok_r;
    prog_nxt   = prog_r;
    found_nxt  = found_r;
    prev_nxt   = prev_r;
    prev_m_nxt = prev_m_r;
    hits_nxt   = hits_r;
    pairs_nxt  = pairs_r;
    ovf_nxt    = ovf_r;

    c       = fold_case(in_text_byte);
    len_m1  = IDX_W'(len - LEN_W'(1));
    matched = (ptr_r < len) && (abbr_f[ptr_r[IDX_W-1:0]] == c);
    for (int k = 0; k < MAX_ABBR_LEN; k++) begin
      eq[k] = (LEN_W'(k) < len) && (abbr_f[k] == c);
    end

    if (!ovf_r && (pos_r >= POS_W'(MAX_TEXT_LEN))) begin
      ovf_nxt = 1'b1;
    end else if (!ovf_r) begin
      if ((pos_r < {2'b0, len}) && (abbr_f[pos_r[IDX_W-1:0]] != c)) begin
        pfx_ok_nxt = 1'b0;
      end
      prog_nxt = {prog_r[MAX_ABBR_LEN-2:0], 1'b1} & eq;
      if ((len != '0) && prog_nxt[len_m1]) begin
        found_nxt = 1'b1;
      end
      if (matched) begin
        ptr_nxt = ptr_r + LEN_W'(1);
        // the two boundary cases never coincide, so one hit at most per byte
        if ((pos_r == '0) || (prev_r == CH_UNDERSCORE) || (prev_r == CH_SPACE) ||
            ((pos_r != '0) && is_lower(prev_r) && is_upper(in_text_byte))) begin
          hits_nxt = hits_r + HITS_W'(1);
        end
        if (prev_m_r && (pos_r != '0)) begin
          pairs_nxt = pairs_r + PAIRS_W'(1);
        end
      end
      prev_m_nxt = matched;
      prev_nxt   = in_text_byte;
      pos_nxt    = pos_r + POS_W'(1);
    end
  end

  // score of the whole text, taken from the updated state
  always @(*) begin
    logic [SCORE_W-1:0] tlen;
    logic [SCORE_W-1:0] hit_pts;
    logic [SCORE_W-1:0] pair_pts;

    tlen     = SCORE_W'(pos_nxt);
    hit_pts  = SCORE_W'(hits_nxt) * SCORE_PER_HIT;
    pair_pts = SCORE_W'(pairs_nxt) * SCORE_PER_PAIR;

    res.score    = '0;
    res.kind     = KIND_NONE;
    res.too_long = 1'b0;
    if (ovf_nxt) begin
      res.too_long = 1'b1;
    end else if (len == '0) begin
      res.score = SCORE_EMPTY;
      res.kind  = KIND_EMPTY;
    end else if (pfx_ok_nxt && (pos_nxt == {2'b0, len})) begin
      res.score = SCORE_EXACT;
      res.kind  = KIND_EXACT;
    end else if (pfx_ok_nxt && (pos_nxt > {2'b0, len})) begin
      res.score = SCORE_PREFIX - SCORE_W'(len);
      res.kind  = KIND_PREFIX;
    end else if (found_nxt) begin
      res.score = SCORE_SUBSTRING - tlen;
      res.kind  = KIND_SUBSTRING;
    end else if (ptr_nxt >= len) begin
      res.score = SCORE_SUBSEQ + hit_pts - tlen + pair_pts;
      res.kind  = KIND_SUBSEQ;
    end
  end

  // configuration registers
  always @(posedge clk) begin
    if (!rst_n) begin
      abbr_lo_r  <= '0;
      abbr_hi_r  <= '0;
      abbr_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ABBR_LO:  abbr_lo_r  <= cfg_data;
        CFG_ABBR_HI:  abbr_hi_r  <= cfg_data;
        CFG_ABBR_LEN: abbr_len_r <= cfg_data[LEN_W-1:0];
        default: ;    // drop writes beyond the register list
      endcase
    end
  end

  // per-text state; clear after the last byte
  always @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pos_r    <= '0;
      ptr_r    <= '0;
      pfx_ok_r <= 1'b1;
      prog_r   <= '0;
      found_r  <= 1'b0;
      prev_r   <= '0;
      prev_m_r <= 1'b0;
      hits_r   <= '0;
      pairs_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      ptr_r    <= ptr_nxt;
      pfx_ok_r <= pfx_ok_nxt;
      prog_r   <= prog_nxt;
      found_r  <= found_nxt;
      prev_r   <= prev_nxt;
      prev_m_r <= prev_m_nxt;
      hits_r   <= hits_nxt;
      pairs_r  <= pairs_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // output register and skid valid flags
  always @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // result payload
  always @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (res_valid) begin
      skid_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_score         = out_res_r.score;
  assign out_match_kind    = out_res_r.kind;
  assign out_text_too_long = out_res_r.too_long;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied while output register empty");

  a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_too_long) |-> (out_score == '0 && out_match_kind == KIND_NONE))
    else $error("overlong text result carries a score");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == '0 && ptr_r == '0 && !ovf_r && pfx_ok_r))
    else $error("text state not cleared after last byte");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= LEN_W'(MAX_ABBR_LEN))
    else $error("subsequence pointer past abbreviation bound");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_TEXT_LEN))
    else $error("text position past maximum length");
`endif

endmodule

/* sim/context_abbrev_match_score_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// context_abbrev_match_score_test
// Streams candidate texts through the abbreviation scorer and checks every
// score against a cycle-free scoring model kept in this bench or a typed
// table score. A short table of hand-picked texts comes first, then random
// phases with own abbreviation settings, six with pressure on both handshakes.
// ----------------------------------------------------------------------------
module context_abbrev_match_score_test
  import cams_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 170;
  localparam int PLAN_ROWS    = 26;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [7:0]            ch;
    logic                  lst;
    logic                  fixed;   // use the typed score instead of the model
    result_t               res;
  } plan_row_t;

  localparam result_t NONE_RES = '{12'd0, KIND_NONE, 1'b0};
  localparam logic [CFG_W-1:0] ALL_ONES = '1;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, 8'h00, 1'b1, 1'b1, '{12'd100, KIND_EMPTY, 1'b0}},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, 8'hFF, 1'b1, 1'b1, '{12'd100, KIND_EMPTY, 1'b0}},
    '{ROW_CFG, CFG_ABBR_LO, 64'h4261, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_CFG, CFG_ABBR_HI, ALL_ONES, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_CFG, CFG_ABBR_LEN, 64'd2, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_CFG, CFG_SPARE, ALL_ONES, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "A", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "b", 1'b1, 1'b1, '{12'd1000, KIND_EXACT, 1'b0}},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "a", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "B", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "c", 1'b1, 1'b1, '{12'd898, KIND_PREFIX, 1'b0}},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "x", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "a", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "b", 1'b1, 1'b1, '{12'd497, KIND_SUBSTRING, 1'b0}},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "a", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "_", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "B", 1'b1, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "x", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "A", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "y", 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "B", 1'b1, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "z", 1'b1, 1'b1, NONE_RES},
    '{ROW_CFG, CFG_ABBR_LEN, 64'd31, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_CFG, CFG_ABBR_LO, ALL_ONES, 8'h00, 1'b0, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, 8'hFF, 1'b1, 1'b0, NONE_RES},
    '{ROW_BYTE, CFG_ABBR_LO, 64'd0, "a", 1'b1, 1'b0, NONE_RES}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_byte = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SCORE_W-1:0]   out_score;
  logic [2:0]           out_match_kind;
  logic                 out_text_too_long;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  context_abbrev_match_score DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_score         (out_score),
    .out_match_kind    (out_match_kind),
    .out_text_too_long (out_text_too_long),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoring model: registers and per-text state
  logic [CFG_W-1:0]   reg_lo = '0;
  logic [CFG_W-1:0]   reg_hi = '0;
  logic [LEN_W-1:0]   reg_len = '0;
  logic [POS_W-1:0]   txt_pos = '0;
  logic [LEN_W-1:0]   sub_ptr = '0;
  logic               pre_ok = 1'b1;
  logic [15:0]        sub_bits = '0;
  logic               sub_hit = 1'b0;
  logic [7:0]         prev_ch = '0;
  logic               prev_hit = 1'b0;
  logic [HITS_W-1:0]  bnd_hits = '0;
  logic [PAIRS_W-1:0] adj_pairs = '0;
  logic               overlong = 1'b0;

  result_t    pending_scores[$];
  logic [7:0] text_buf[$];
  logic [7:0] abbr_txt [MAX_ABBR_LEN];
  int         abbr_n = 0;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 74;
  int         errors = 0;
  int         n_results = 0;
  int         cycles = 0;

  function automatic logic upper_letter(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic lower_letter(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    return upper_letter(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] abbr_char(input int k);
    return fold_letter(k < 8 ? reg_lo[k*8 +: 8] : reg_hi[(k-8)*8 +: 8]);
  endfunction

  // advance the scoring model by one text byte; got is set on the final byte
  task automatic score_text_byte(input logic [7:0] raw, input logic lst,
                                 output bit got, output result_t res);
    logic [LEN_W-1:0] n;
    logic [7:0]       c;
    logic [15:0]      eq;
    logic             hit;
    int               total;
    n = (reg_len > MAX_ABBR_LEN) ? LEN_W'(MAX_ABBR_LEN) : reg_len;
    got = 1'b0;
    res = NONE_RES;
    if (!overlong && txt_pos >= MAX_TEXT_LEN) begin
      overlong = 1'b1;
    end else if (!overlong) begin
      c = fold_letter(raw);
      eq = '0;
      hit = 1'b0;
      if (txt_pos < n && abbr_char(int'(txt_pos)) != c) pre_ok = 1'b0;
      for (int k = 0; k < MAX_ABBR_LEN; k++)
        if (k < n && abbr_char(k) == c) eq[k] = 1'b1;
      sub_bits = {sub_bits[14:0], 1'b1} & eq;
      if (n > 0 && sub_bits[n-1]) sub_hit = 1'b1;
      if (sub_ptr < n && abbr_char(int'(sub_ptr)) == c) begin
        hit = 1'b1;
        sub_ptr++;
        if (txt_pos == 0 || prev_ch == CH_UNDERSCORE || prev_ch == CH_SPACE) bnd_hits++;
        if (txt_pos > 0 && lower_letter(prev_ch) && upper_letter(raw)) bnd_hits++;
        if (prev_hit && txt_pos > 0) adj_pairs++;
      end
      prev_hit = hit;
      prev_ch = raw;
      txt_pos++;
    end
    if (lst) begin
      got = 1'b1;
      if (overlong) begin
        res.too_long = 1'b1;
      end else if (n == 0) begin
        res.score = 12'd100;
        res.kind = KIND_EMPTY;
      end else if (pre_ok && txt_pos == n) begin
        res.score = 12'd1000;
        res.kind = KIND_EXACT;
      end else if (pre_ok && txt_pos > n) begin
        total = 800 + 100 - int'(n);
        res.score = total[SCORE_W-1:0];
        res.kind = KIND_PREFIX;
      end else if (sub_hit) begin
        total = 400 + 100 - int'(txt_pos);
        res.score = total[SCORE_W-1:0];
        res.kind = KIND_SUBSTRING;
      end else if (sub_ptr >= n) begin
        total = 500 + 50 * int'(bnd_hits) - int'(txt_pos) + 10 * int'(adj_pairs);
        res.score = total[SCORE_W-1:0];
        res.kind = KIND_SUBSEQ;
      end
      txt_pos = '0;
      sub_ptr = '0;
      pre_ok = 1'b1;
      sub_bits = '0;
      sub_hit = 1'b0;
      prev_ch = '0;
      prev_hit = 1'b0;
      bnd_hits = '0;
      adj_pairs = '0;
      overlong = 1'b0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] ch, input logic lst, input logic fixed,
                           input result_t given);
    result_t res;
    bit      got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= ch;
    in_last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    score_text_byte(ch, lst, got, res);
    if (got) pending_scores.push_back(fixed ? given : res);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ABBR_LO:  reg_lo = val;
      CFG_ABBR_HI:  reg_hi = val;
      CFG_ABBR_LEN: reg_len = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold the input until every score is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] recase(input logic [7:0] c);
    if ((upper_letter(c) || lower_letter(c)) && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] filler();
    case ($urandom_range(0, 9))
      0:       return CH_UNDERSCORE;
      1:       return CH_SPACE;
      2, 3, 4, 5: return 8'(8'h61 + $urandom_range(0, 7));
      6, 7, 8: return 8'(8'h41 + $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic load_abbreviation(input int p);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [LEN_W-1:0] len;
    logic [7:0]       c;
    int               r;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case (p)
      1:       len = '0;
      4:       len = LEN_W'(MAX_ABBR_LEN);
      7:       len = LEN_W'($urandom_range(MAX_ABBR_LEN + 1, 31));
      default: len = LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                          : $urandom_range(1, 6));
    endcase
    abbr_n = (len > MAX_ABBR_LEN) ? MAX_ABBR_LEN : int'(len);
    for (int k = 0; k < abbr_n; k++) begin
      r = $urandom_range(0, 99);
      c = 8'(8'h61 + $urandom_range(0, 5));
      if (r < 20) c = c ^ 8'h20;
      else if (r >= 95) c = 8'($urandom_range(0, 255));
      abbr_txt[k] = c;
      if (k < 8) lo[k*8 +: 8] = c;
      else hi[(k-8)*8 +: 8] = c;
    end
    write_reg(CFG_ABBR_LO, lo);
    write_reg(CFG_ABBR_HI, hi);
    write_reg(CFG_ABBR_LEN, CFG_W'(len));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
  endtask

  // shape a text around the current abbreviation so every score class shows up
  task automatic build_text(input bit force_long);
    int r;
    int fill;
    text_buf.delete();
    r = force_long ? 100 : $urandom_range(0, 99);
    if (r < 10) begin
      for (int k = 0; k < abbr_n; k++) text_buf.push_back(recase(abbr_txt[k]));
    end else if (r < 20) begin
      for (int k = 0; k < abbr_n; k++) text_buf.push_back(recase(abbr_txt[k]));
      repeat ($urandom_range(1, 5)) text_buf.push_back(filler());
    end else if (r < 35) begin
      repeat ($urandom_range(1, 4)) text_buf.push_back(filler());
      for (int k = 0; k < abbr_n; k++) text_buf.push_back(recase(abbr_txt[k]));
      repeat ($urandom_range(0, 4)) text_buf.push_back(filler());
    end else if (r < 75) begin
      for (int k = 0; k < abbr_n; k++) begin
        repeat ($urandom_range(0, 3)) text_buf.push_back(filler());
        text_buf.push_back(recase(abbr_txt[k]));
      end
      repeat ($urandom_range(0, 2)) text_buf.push_back(filler());
    end else if (r < 96) begin
      repeat ($urandom_range(1, 12))
        text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : filler());
    end else begin
      fill = force_long ? $urandom_range(MAX_TEXT_LEN + 1, MAX_TEXT_LEN + 12)
                        : $urandom_range(MAX_TEXT_LEN - 1, MAX_TEXT_LEN + 12);
      repeat (fill) text_buf.push_back(filler());
    end
    if (text_buf.size() == 0) text_buf.push_back(filler());
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin : check_scores
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        if (errors < 10)
          $display("result %0d unexpected: score %0d kind %0d too_long %0b",
                   n_results, out_score, out_match_kind, out_text_too_long);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (out_score !== want.score || out_match_kind !== want.kind ||
            out_text_too_long !== want.too_long) begin
          if (errors < 10)
            $display("result %0d: expected score %0d kind %0d too_long %0b, got %0d %0d %0b",
                     n_results, want.score, want.kind, want.too_long,
                     out_score, out_match_kind, out_text_too_long);
          errors++;
        end
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].op == ROW_CFG) begin
        settle();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_byte(PLAN[r].ch, PLAN[r].lst, PLAN[r].fixed, PLAN[r].res);
      end
    end

    for (int p = 0; p < 9; p++) begin
      settle();
      case (p / 3)
        0: begin send_idle_pct = 18; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      load_abbreviation(p);
      sent = 0;
      // open each phase with an overlong text
      build_text(1'b1);
      while (sent < PHASE_BYTES) begin
        for (int i = 0; i < text_buf.size(); i++)
          send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, NONE_RES);
        sent += text_buf.size();
        if ($urandom_range(0, 29) == 0) settle();
        build_text(1'b0);
      end
    end

    settle();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
